### hw/rtl/gsel_pkg.sv
package gsel_pkg;

  // Default table geometry.
  localparam int unsigned PC_INDEX_BITS = 10;
  localparam int unsigned HISTORY_BITS  = 2;

  localparam int unsigned CNT_W = 2;

  // Counter codes of the hysteresis automaton.
  localparam logic [CNT_W-1:0] CNT_STRONG_NOT_TAKEN = 2'd0;
  localparam logic [CNT_W-1:0] CNT_WEAK_NOT_TAKEN   = 2'd1;
  localparam logic [CNT_W-1:0] CNT_WEAK_TAKEN       = 2'd2;
  localparam logic [CNT_W-1:0] CNT_STRONG_TAKEN     = 2'd3;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_STRONG_TAKEN;

  // A taken branch saturates the counter unless it is strongly not taken;
  // a not-taken branch drops it to strongly not taken unless it is strongly taken.
  function automatic logic [CNT_W-1:0] next_counter(input logic [CNT_W-1:0] cur,
                                                     input logic            taken);
    logic [CNT_W-1:0] nxt;
    if (taken) begin
      nxt = (cur == CNT_STRONG_NOT_TAKEN) ? CNT_WEAK_NOT_TAKEN : CNT_STRONG_TAKEN;
    end else begin
      nxt = (cur == CNT_STRONG_TAKEN) ? CNT_WEAK_TAKEN : CNT_STRONG_NOT_TAKEN;
    end
    return nxt;
  endfunction

endpackage

### hw/rtl/gsel_table.sv
module gsel_table #(
  parameter int unsigned IdxBits = gsel_pkg::PC_INDEX_BITS + gsel_pkg::HISTORY_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [IdxBits-1:0]         rd_addr_i,
  output logic [gsel_pkg::CNT_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [IdxBits-1:0]         wr_addr_i,
  input  logic [gsel_pkg::CNT_W-1:0] wr_data_i,
  output logic                       busy_o
);

  localparam int unsigned Depth = 1 << IdxBits;

  logic [gsel_pkg::CNT_W-1:0] mem [Depth];
  logic [gsel_pkg::CNT_W-1:0] rd_data_q;

  logic               clr_active_q, clr_active_d;
  logic [IdxBits-1:0] clr_addr_q, clr_addr_d;

  logic                       mem_we;
  logic [IdxBits-1:0]         mem_waddr;
  logic [gsel_pkg::CNT_W-1:0] mem_wdata;

  // After reset every entry is swept back to strongly taken, one per cycle.
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + IdxBits'(1);
      if (clr_addr_q == {IdxBits{1'b1}}) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  assign mem_we    = clr_active_q | wr_en_i;
  assign mem_waddr = clr_active_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_active_q ? gsel_pkg::CNT_RESET : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_active_q;

endmodule

### hw/rtl/global_history_branch_predictor_top.sv
// Gselect branch predictor. Each request carries one resolved branch (its
// address and outcome) and yields one prediction, the top bit of the 2-bit
// counter selected by the global history joined to the low address bits, read
// before that counter is updated. One request is taken per cycle while the
// input is not stalled; a prediction passes the s1 stage (table read) and
// then the output register. The counters live in a single-port-read,
// single-port-write memory with a registered read; a write-back of the
// previous branch to the same entry is forwarded. After reset the block clears
// all 2^(HistoryBits + PcIndexBits) entries (4096 by default), stalling input.
module global_history_branch_predictor_top #(
  parameter int unsigned PcIndexBits = gsel_pkg::PC_INDEX_BITS,
  parameter int unsigned HistoryBits = gsel_pkg::HISTORY_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] branch_pc_i,
  input  logic        outcome_taken_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        predict_taken_o
);

  localparam int unsigned IdxBits = PcIndexBits + HistoryBits;

  logic in_accept;
  logic tbl_busy;

  logic [HistoryBits-1:0] hist_q, hist_d;
  logic [IdxBits-1:0]     rd_idx;

  logic                       s1_valid_q, s1_valid_d;
  logic [IdxBits-1:0]         s1_idx_q;
  logic                       s1_taken_q;
  logic                       s1_adv;
  logic [gsel_pkg::CNT_W-1:0] rd_data;
  logic [gsel_pkg::CNT_W-1:0] cur_cnt;
  logic [gsel_pkg::CNT_W-1:0] new_cnt;

  logic                       fwd_valid_q;
  logic [IdxBits-1:0]         fwd_idx_q;
  logic [gsel_pkg::CNT_W-1:0] fwd_data_q;

  logic out_valid_q, out_valid_d;
  logic out_pred_q;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = tbl_busy | (s1_valid_q & ~s1_adv);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign rd_idx = {hist_q, branch_pc_i[PcIndexBits-1:0]};
  assign hist_d = (hist_q >> 1) | (HistoryBits'(outcome_taken_i) << (HistoryBits - 1));

  // The forward register always holds the latest write-back, so it is correct
  // whether or not the memory read already saw it.
  assign cur_cnt = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_data_q : rd_data;
  assign new_cnt = gsel_pkg::next_counter(cur_cnt, s1_taken_q);

  gsel_table #(
    .IdxBits(IdxBits)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_addr_i(rd_idx),
    .rd_data_o(rd_data),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_idx_q),
    .wr_data_i(new_cnt),
    .busy_o   (tbl_busy)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '1;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        hist_q <= hist_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q   <= rd_idx;
      s1_taken_q <= outcome_taken_i;
    end
    if (s1_adv) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= new_cnt;
      out_pred_q <= cur_cnt[gsel_pkg::CNT_W-1];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = out_pred_q;

endmodule

### tb/sv/tb_global_history_branch_predictor_top.sv
`timescale 1ns / 100ps

module tb_global_history_branch_predictor_top;

  localparam int unsigned PCB = gsel_pkg::PC_INDEX_BITS;
  localparam int unsigned HB = gsel_pkg::HISTORY_BITS;
  localparam int unsigned TABLE_DEPTH = 1 << (PCB + HB);
  localparam int unsigned RANDOM_BRANCHES = 1900;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Mirrors the counter table and global history and keeps the predictions
  // still owed by the block, oldest first.
  class gsel_scoreboard;
    logic [HB-1:0] history;
    logic [gsel_pkg::CNT_W-1:0] counters [TABLE_DEPTH];
    logic pending_predictions [$];
    int errors;
    int checked;
    int taken_seen;

    function new();
      history = '1;
      foreach (counters[i]) counters[i] = gsel_pkg::CNT_RESET;
      errors = 0;
      checked = 0;
      taken_seen = 0;
    endfunction

    function void note_branch(logic [31:0] pc, logic taken);
      logic [PCB+HB-1:0] idx;
      logic [gsel_pkg::CNT_W-1:0] cur;
      idx = {history, pc[PCB-1:0]};
      cur = counters[idx];
      pending_predictions.push_back(cur[gsel_pkg::CNT_W-1]);
      case (cur)
        gsel_pkg::CNT_STRONG_TAKEN: begin
          counters[idx] = taken ? gsel_pkg::CNT_STRONG_TAKEN : gsel_pkg::CNT_WEAK_TAKEN;
        end
        gsel_pkg::CNT_WEAK_TAKEN, gsel_pkg::CNT_WEAK_NOT_TAKEN: begin
          counters[idx] = taken ? gsel_pkg::CNT_STRONG_TAKEN : gsel_pkg::CNT_STRONG_NOT_TAKEN;
        end
        default: begin
          counters[idx] = taken ? gsel_pkg::CNT_WEAK_NOT_TAKEN
                                : gsel_pkg::CNT_STRONG_NOT_TAKEN;
        end
      endcase
      // The newest outcome enters at the top and older ones move down.
      history = HB'({taken, history} >> 1);
    endfunction

    function void check_prediction(logic got);
      logic want;
      if (pending_predictions.size() == 0) begin
        errors++;
        $error("predict_taken: unexpected result %0b with no request outstanding", got);
      end else begin
        want = pending_predictions.pop_front();
        checked++;
        if (got) taken_seen++;
        if (got !== want) begin
          errors++;
          $error("predict_taken mismatch: expected %0b, actual %0b", want, got);
        end
      end
    endfunction

    function int outstanding();
      return pending_predictions.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] branch_pc = '0;
  logic outcome_taken = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic predict_taken;

  gsel_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int branches_sent = 0;

  global_history_branch_predictor_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .branch_pc_i    (branch_pc),
    .outcome_taken_i(outcome_taken),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .predict_taken_o(predict_taken)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watches both channels; the watchdog only counts cycles without any
  // transfer, so the table clear after reset fits well inside the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_branch(branch_pc, outcome_taken);
      if (out_valid && !out_stall) sb.check_prediction(predict_taken);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d predictions outstanding.", sb.outstanding());
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_branch(input logic [31:0] pc, input logic taken);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    branch_pc <= pc;
    outcome_taken <= taken;
    do @(posedge clk); while (in_stall);
    branches_sent++;
  endtask

  task automatic send_random_branches(input int count);
    logic [31:0] pc;
    logic [PCB-1:0] hot_index [8];
    int hot_bias [8];
    int k;
    hot_bias = '{95, 5, 50, 80, 20, 99, 1, 60};
    foreach (hot_index[i]) hot_index[i] = PCB'($urandom);
    for (int n = 0; n < count; n++) begin
      pc = $urandom;
      if ($urandom_range(99) < 70) begin
        // Mostly a few hot branches with their own bias, so that the
        // counters walk through every state under varied histories.
        k = $urandom_range(7);
        pc[PCB-1:0] = hot_index[k];
        send_branch(pc, $urandom_range(99) < hot_bias[k]);
      end else begin
        send_branch(pc, 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] directed_pc [21];
    logic directed_taken [21];
    int gap_plan [4];
    int stall_plan [4];
    int directed_count;

    // History runs down to all zeros so that one entry can be stepped through every
    // counter state; some addresses differ only above the index.
    directed_pc = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'hABCD_E005,
                    32'h0000_0005, 32'hFFFF_FC05, 32'h0000_0006, 32'h0000_0006,
                    32'h0000_0005, 32'h0000_0005, 32'h0000_0006, 32'h0000_0006,
                    32'h0000_0005, 32'h0000_0006, 32'h0000_0006, 32'h0000_0005,
                    32'h0000_0005, 32'h0000_03FF, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h0000_03FF};
    directed_taken = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                       1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                       1'b0};
    gap_plan = '{0, 61, 0, 23};
    stall_plan = '{0, 0, 61, 23};

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_pc[i]) send_branch(directed_pc[i], directed_taken[i]);
    directed_count = branches_sent;

    for (int phase = 0; phase < 4; phase++) begin
      gap_pct = gap_plan[phase];
      stall_pct = stall_plan[phase];
      send_random_branches(RANDOM_BRANCHES / 4);
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d branches (%0d directed, the rest random under four idle/stall mixes).",
             branches_sent, directed_count);
    $display("Checked %0d predictions, %0d of them taken; %0d mismatches.",
             sb.checked, sb.taken_seen, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
